// ===== rtl/core/text_terminal_char_grid_core_assert.svh =====
// Assertion macros for the character grid core.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef TEXT_TERMINAL_CHAR_GRID_CORE_ASSERT_SVH
`define TEXT_TERMINAL_CHAR_GRID_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TTCG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttcg: assertion failed");
`define TTCG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttcg: assertion failed");
`else
`define TTCG_ASSERT_NOW(lbl, ante, cons)
`define TTCG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/ttcg_pkg.sv =====
// Shared constants, codes and inter-module structs of the character grid core.
// No dependencies; imported by ttcg_rowmap, ttcg_ctrl and the top level.
package ttcg_pkg;

  localparam int GRID_COLS = 80;
  localparam int GRID_ROWS = 39;

  localparam int CHAR_W   = 7;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 6;
  localparam int FUNC_W   = 3;
  localparam int CODE_W   = 8;
  localparam int PERIOD_W = 16;

  localparam int ROW_IDX_W = $clog2(GRID_ROWS);
  localparam int CELLS     = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W    = $clog2(CELLS);

  // tab stops every 8 columns
  localparam int TAB_BITS = 3;

  localparam logic [COL_W-1:0]    LAST_COL     = COL_W'(GRID_COLS - 1);
  localparam logic [ROW_W-1:0]    LAST_ROW     = ROW_W'(GRID_ROWS - 1);
  localparam logic [PERIOD_W-1:0] BLINK_RESET  = PERIOD_W'(500);

  localparam logic [CHAR_W-1:0] SPACE_CHAR      = 7'd32;
  localparam logic [CHAR_W-1:0] PRINT_LAST_CHAR = 7'd126;

  localparam logic [CODE_W-1:0] CH_BS    = 8'd8;
  localparam logic [CODE_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CODE_W-1:0] CH_LF    = 8'd10;
  localparam logic [CODE_W-1:0] CH_CR    = 8'd13;
  localparam logic [CODE_W-1:0] CH_FIRST = 8'd32;
  localparam logic [CODE_W-1:0] CH_LAST  = 8'd126;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUT   = 3'd0,
    FN_LEFT  = 3'd1,
    FN_RIGHT = 3'd2,
    FN_UP    = 3'd3,
    FN_DOWN  = 3'd4,
    FN_READ  = 3'd5,
    FN_TICK  = 3'd6
  } func_t;

  // sequencer -> row map
  typedef struct packed {
    logic             scroll;
    logic             set_valid;
    logic [ROW_W-1:0] q_row;
  } rm_cmd_t;

  // row map -> sequencer
  typedef struct packed {
    logic              row_valid;
    logic [ADDR_W-1:0] base;
  } rm_stat_t;

endpackage

// ===== rtl/core/ttcg_ram.sv =====
// Generic single-port synchronous RAM; read data is registered and appears in the cycle after the access.
// No dependencies.
module ttcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/ttcg_rowmap.sv =====
// Row map: circular top-row pointer and per-row valid bits of the grid RAM.
// Depends on ttcg_pkg.
module ttcg_rowmap import ttcg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  rm_cmd_t  cmd,
  output rm_stat_t stat
);

  logic [ROW_IDX_W-1:0] top_r;
  logic [ROW_IDX_W-1:0] phys_r;
  logic [ROW_IDX_W-1:0] phys_nxt;
  logic [GRID_ROWS-1:0] valid_r;
  logic [ROW_W:0]       sum;

  // logical row -> physical row, modulo the row count
  always_comb begin
    sum = {1'b0, cmd.q_row} + (ROW_W+1)'(top_r);
    if (cmd.q_row > LAST_ROW) begin
      phys_nxt = '0;
    end else if (sum >= (ROW_W+1)'(GRID_ROWS)) begin
      phys_nxt = ROW_IDX_W'(sum - (ROW_W+1)'(GRID_ROWS));
    end else begin
      phys_nxt = ROW_IDX_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r   <= '0;
      phys_r  <= '0;
      valid_r <= '0;
    end else begin
      phys_r <= phys_nxt;
      if (cmd.scroll) begin
        // old top row becomes the new bottom row, blank
        valid_r[top_r] <= 1'b0;
        top_r <= (top_r == ROW_IDX_W'(GRID_ROWS - 1)) ? '0 : top_r + 1'b1;
      end
      if (cmd.set_valid) begin
        valid_r[phys_r] <= 1'b1;
      end
    end
  end

  assign stat.row_valid = valid_r[phys_r];
  assign stat.base      = ADDR_W'(phys_r) * ADDR_W'(GRID_COLS);

endmodule

// ===== rtl/core/ttcg_ctrl.sv =====
// Item sequencer: cursor, blink counter, put-char handling and result register.
// Depends on ttcg_pkg; drives ttcg_rowmap and the grid RAM.
module ttcg_ctrl import ttcg_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [CODE_W-1:0]   in_char_code,
  input  logic [ROW_W-1:0]    in_read_row,
  input  logic [COL_W-1:0]    in_read_col,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CHAR_W-1:0]   out_cell_char,
  output logic [COL_W-1:0]    out_cursor_col,
  output logic [ROW_W-1:0]    out_cursor_row,
  output logic                out_cursor_visible,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [PERIOD_W-1:0] cfg_data,
  output rm_cmd_t             rm_cmd,
  input  rm_stat_t            rm_stat,
  output logic                mem_en,
  output logic                mem_we,
  output logic [ADDR_W-1:0]   mem_addr,
  output logic [CHAR_W-1:0]   mem_wdata,
  input  logic [CHAR_W-1:0]   mem_rdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_SETTLE, S_EXEC, S_RESEAT, S_PUT, S_CLEAR, S_RDATA, S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [COL_W-1:0]    cx_r, cx_nxt;
  logic [ROW_W-1:0]    cy_r, cy_nxt;
  logic                shown_r, shown_nxt;
  logic [PERIOD_W-1:0] bcount_r, bcount_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic                ovalid_r, ovalid_nxt;

  logic [FUNC_W-1:0]   func_r, func_nxt;
  logic [CODE_W-1:0]   code_r, code_nxt;
  logic [ROW_W-1:0]    rrow_r, rrow_nxt;
  logic [COL_W-1:0]    rcol_r, rcol_nxt;
  logic [CHAR_W-1:0]   ch_r, ch_nxt;
  logic [CHAR_W-1:0]   cell_r, cell_nxt;
  logic [COL_W-1:0]    sweep_r, sweep_nxt;
  logic [CHAR_W-1:0]   ocell_r, ocell_nxt;
  logic [COL_W-1:0]    ocol_r, ocol_nxt;
  logic [ROW_W-1:0]    orow_r, orow_nxt;
  logic                ovis_r, ovis_nxt;

  logic                nl_scroll;
  logic [ROW_W-1:0]    nl_cy;
  logic [COL_W-1:0]    cx_p1;
  logic [PERIOD_W:0]   bc_p1;

  always_comb begin
    nl_scroll = (cy_r == LAST_ROW);
    nl_cy     = nl_scroll ? cy_r : cy_r + 1'b1;
    cx_p1     = cx_r + 1'b1;
    bc_p1     = {1'b0, bcount_r} + 1'b1;

    state_nxt  = state_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    shown_nxt  = shown_r;
    bcount_nxt = bcount_r;
    period_nxt = cfg_valid ? cfg_data : period_r;
    ovalid_nxt = ovalid_r && !out_ready;
    func_nxt   = func_r;
    code_nxt   = code_r;
    rrow_nxt   = rrow_r;
    rcol_nxt   = rcol_r;
    ch_nxt     = ch_r;
    cell_nxt   = cell_r;
    sweep_nxt  = sweep_r;
    ocell_nxt  = ocell_r;
    ocol_nxt   = ocol_r;
    orow_nxt   = orow_r;
    ovis_nxt   = ovis_r;

    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = rm_stat.base + ADDR_W'(cx_r);
    mem_wdata = ch_r;

    rm_cmd.scroll    = 1'b0;
    rm_cmd.set_valid = 1'b0;
    rm_cmd.q_row     = (func_r == FN_READ) ? rrow_r : cy_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_func;
          code_nxt  = in_char_code;
          rrow_nxt  = in_read_row;
          rcol_nxt  = in_read_col;
          cell_nxt  = SPACE_CHAR;
          state_nxt = S_SETTLE;
        end
      end

      // row map picks up the row of this item
      S_SETTLE: state_nxt = S_EXEC;

      S_EXEC: begin
        state_nxt = S_DONE;
        case (func_r)
          FN_PUT: begin
            if (code_r == CH_CR) begin
              cx_nxt = '0;
            end else if (code_r == CH_LF) begin
              cx_nxt        = '0;
              cy_nxt        = nl_cy;
              rm_cmd.scroll = nl_scroll;
            end else if (code_r == CH_BS) begin
              if (cx_r != '0) begin
                cx_nxt    = cx_r - 1'b1;
                ch_nxt    = SPACE_CHAR;
                state_nxt = S_PUT;
              end else if (cy_r != '0) begin
                cy_nxt    = cy_r - 1'b1;
                cx_nxt    = LAST_COL;
                ch_nxt    = SPACE_CHAR;
                state_nxt = S_RESEAT;
              end
            end else if (code_r == CH_TAB) begin
              ch_nxt    = SPACE_CHAR;
              state_nxt = S_PUT;
            end else if (code_r inside {[CH_FIRST:CH_LAST]}) begin
              ch_nxt    = code_r[CHAR_W-1:0];
              state_nxt = S_PUT;
            end
          end
          FN_LEFT:  if (cx_r != '0) cx_nxt = cx_r - 1'b1;
          FN_RIGHT: if (cx_r != LAST_COL) cx_nxt = cx_p1;
          FN_UP:    if (cy_r != '0) cy_nxt = cy_r - 1'b1;
          FN_DOWN:  if (cy_r != LAST_ROW) cy_nxt = cy_r + 1'b1;
          FN_READ: begin
            if (rrow_r <= LAST_ROW && rcol_r <= LAST_COL && rm_stat.row_valid) begin
              mem_en    = 1'b1;
              mem_addr  = rm_stat.base + ADDR_W'(rcol_r);
              state_nxt = S_RDATA;
            end
          end
          FN_TICK: begin
            if (bc_p1 >= {1'b0, period_r}) begin
              bcount_nxt = '0;
              shown_nxt  = !shown_r;
            end else begin
              bcount_nxt = bc_p1[PERIOD_W-1:0];
            end
          end
          default: ;
        endcase
      end

      // row changed by a backspace over the row start
      S_RESEAT: state_nxt = S_PUT;

      S_PUT: begin
        if (!rm_stat.row_valid && ch_r != SPACE_CHAR) begin
          sweep_nxt = '0;
          state_nxt = S_CLEAR;
        end else begin
          // a space into a blank row changes nothing
          mem_en = rm_stat.row_valid;
          mem_we = rm_stat.row_valid;
          if (code_r == CH_BS) begin
            state_nxt = S_DONE;
          end else if (cx_r == LAST_COL) begin
            cx_nxt        = '0;
            cy_nxt        = nl_cy;
            rm_cmd.scroll = nl_scroll;
            state_nxt     = S_DONE;
          end else begin
            cx_nxt = cx_p1;
            if (code_r != CH_TAB || cx_p1[TAB_BITS-1:0] == '0) begin
              state_nxt = S_DONE;
            end
          end
        end
      end

      S_CLEAR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = rm_stat.base + ADDR_W'(sweep_r);
        mem_wdata = SPACE_CHAR;
        if (sweep_r == LAST_COL) begin
          rm_cmd.set_valid = 1'b1;
          state_nxt        = S_PUT;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end

      S_RDATA: begin
        cell_nxt  = mem_rdata;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!ovalid_r || out_ready) begin
          ocell_nxt  = cell_r;
          ocol_nxt   = cx_r;
          orow_nxt   = cy_r;
          ovis_nxt   = shown_r;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    code_r  <= code_nxt;
    rrow_r  <= rrow_nxt;
    rcol_r  <= rcol_nxt;
    ch_r    <= ch_nxt;
    cell_r  <= cell_nxt;
    sweep_r <= sweep_nxt;
    ocell_r <= ocell_nxt;
    ocol_r  <= ocol_nxt;
    orow_r  <= orow_nxt;
    ovis_r  <= ovis_nxt;
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cx_r     <= '0;
      cy_r     <= '0;
      shown_r  <= 1'b1;
      bcount_r <= '0;
      period_r <= BLINK_RESET;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      shown_r  <= shown_nxt;
      bcount_r <= bcount_nxt;
      period_r <= period_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign in_ready           = (state_r == S_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = ovalid_r;
  assign out_cell_char      = ocell_r;
  assign out_cursor_col     = ocol_r;
  assign out_cursor_row     = orow_r;
  assign out_cursor_visible = ovis_r;

endmodule

// ===== rtl/core/text_terminal_char_grid_core.sv =====
// Text terminal character grid core, 39 rows x 80 columns of 7-bit characters.
// Depends on ttcg_pkg, ttcg_ctrl, ttcg_rowmap, ttcg_ram and the assertion header.
//
// Usage:
//  - in_* channel (valid/ready): one item per command; in_func selects put char,
//    cursor left/right/up/down, read cell or blink tick. Every item gives exactly
//    one result on out_* (valid/ready): cell character (space unless a read),
//    cursor column/row and cursor visibility after the item.
//  - cfg_* channel: writes the blink period; always ready, write only when idle.
//  - Items are handled one at a time. A tab writes one RAM cell per column up to
//    the next tab stop, and a backspace into the previous row passes through an
//    extra reseat state. A first non-space character in a blank row sweeps that
//    row with spaces first, one cell per cycle. The next item is taken the cycle
//    after its result is loaded.
//  - Scrolling: the top-row pointer moves and the old top row goes blank in the same cycle.
//  - Reset: cursor home, cursor shown, blink period 500, all rows marked blank
//    at once (no clearing pass), ready once the state register has been reset.
//  - The result sits in an output register; a new item is taken while it waits,
//    and that item stalls only at its own result if out_ready stays low.
`include "text_terminal_char_grid_core_assert.svh"

module text_terminal_char_grid_core import ttcg_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // item input
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [CODE_W-1:0]   in_char_code,
  input  logic [ROW_W-1:0]    in_read_row,
  input  logic [COL_W-1:0]    in_read_col,
  // result output
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CHAR_W-1:0]   out_cell_char,
  output logic [COL_W-1:0]    out_cursor_col,
  output logic [ROW_W-1:0]    out_cursor_row,
  output logic                out_cursor_visible,
  // blink period write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [PERIOD_W-1:0] cfg_data
);

  rm_cmd_t             rm_cmd;
  rm_stat_t            rm_stat;
  logic                mem_en;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_addr;
  logic [CHAR_W-1:0]   mem_wdata;
  logic [CHAR_W-1:0]   mem_rdata;

  // sequencer: cursor, blink, put-char steps, result register
  ttcg_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_char_code       (in_char_code),
    .in_read_row        (in_read_row),
    .in_read_col        (in_read_col),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_cell_char      (out_cell_char),
    .out_cursor_col     (out_cursor_col),
    .out_cursor_row     (out_cursor_row),
    .out_cursor_visible (out_cursor_visible),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .rm_cmd             (rm_cmd),
    .rm_stat            (rm_stat),
    .mem_en             (mem_en),
    .mem_we             (mem_we),
    .mem_addr           (mem_addr),
    .mem_wdata          (mem_wdata),
    .mem_rdata          (mem_rdata)
  );

  // logical -> physical row, blank-row tracking
  ttcg_rowmap u_rowmap (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (rm_cmd),
    .stat  (rm_stat)
  );

  // character grid, row-major by physical row
  ttcg_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELLS)
  ) u_grid_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // results stay on the grid and in the printable set
  `TTCG_ASSERT_NOW(a_out_in_grid, out_valid, (out_cursor_col <= LAST_COL) && (out_cursor_row <= LAST_ROW))
  `TTCG_ASSERT_NOW(a_out_printable, out_valid, (out_cell_char >= SPACE_CHAR) && (out_cell_char <= PRINT_LAST_CHAR))
  // one item in flight: taking an item drops ready next cycle
  `TTCG_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)
  // a scroll never coincides with a row being marked written
  `TTCG_ASSERT_NOW(a_cmd_excl, rm_cmd.scroll, !rm_cmd.set_valid)

endmodule
